@@ design/gde_pkg.sv @@
// Shared constants, types and constant tables for the Gaussian density evaluator.
// Holds the exp(-x) lookup tables, built at elaboration by an integer Taylor series.
// Used by gde_exp and gaussian_density_eval; depends on nothing else.
package gde_pkg;

  // exp table sizing
  localparam int EXP_TABLE_BITS = 8;
  localparam int INT_TAB_SIZE   = 128;
  localparam int INT_IDX_W      = 7;
  localparam int FRAC_TAB_SIZE  = 1 << EXP_TABLE_BITS;
  localparam int TAYLOR_TERMS   = 20;
  localparam int LO_W           = 16 - EXP_TABLE_BITS;
  localparam int R_W            = LO_W + 15;

  // e = z*z/2 in Q16.16 stays below 2^23
  localparam int E_W            = 23;
  localparam int Z_W            = 20;

  localparam logic [31:0] ONE_Q31          = 32'h8000_0000;
  localparam logic [30:0] INV_SQRT_2PI_Q32 = 31'd1713444047;

  // floor(x/6) = (x * ceil(2^30/6)) >> 30, exact for x < 2^29
  localparam int          DIV6_SHIFT = 30;
  localparam logic [27:0] DIV6_RECIP = 28'd178956971;

  // pipeline depths
  localparam int DIV1_STEPS = Z_W;
  localparam int DIV2_STEPS = 31;
  localparam int EXP_LAT    = 6;

  // configuration register indexes
  localparam logic REG_MEAN = 1'b0;
  localparam logic REG_DEV  = 1'b1;

  // what the final stage does with an item
  typedef enum logic [1:0] {
    KIND_NORM,
    KIND_ZERO,
    KIND_TAIL
  } kind_t;

  typedef logic [31:0] int_tab_t [INT_TAB_SIZE];
  typedef logic [31:0] frac_tab_t [FRAC_TAB_SIZE];

  // Divide one Taylor term by its index
  function automatic logic [63:0] div_term(input logic [63:0] t, input int i);
    logic [63:0] res;
    unique case (i)
      1:       res = t;
      2:       res = t / 2;
      3:       res = t / 3;
      4:       res = t / 4;
      5:       res = t / 5;
      6:       res = t / 6;
      7:       res = t / 7;
      8:       res = t / 8;
      9:       res = t / 9;
      10:      res = t / 10;
      11:      res = t / 11;
      12:      res = t / 12;
      13:      res = t / 13;
      14:      res = t / 14;
      15:      res = t / 15;
      16:      res = t / 16;
      17:      res = t / 17;
      18:      res = t / 18;
      19:      res = t / 19;
      20:      res = t / 20;
      default: res = t;
    endcase
    return res;
  endfunction

  // exp(-x) for x in Q1.31, 0 <= x <= 1.0; result in Q1.31
  function automatic logic [31:0] taylor_exp_neg(input logic [63:0] x);
    logic signed [65:0] sum;
    logic [63:0]        term;
    sum  = 66'(ONE_Q31);
    term = 64'(ONE_Q31);
    for (int i = 1; i <= TAYLOR_TERMS; i++) begin
      term = div_term((term * x) >> 31, i);
      if (i[0]) begin
        sum = sum - $signed({2'b00, term});
      end else begin
        sum = sum + $signed({2'b00, term});
      end
    end
    if (sum < 0) begin
      sum = '0;
    end
    return sum[31:0];
  endfunction

  function automatic int_tab_t build_int_pow();
    int_tab_t    t;
    logic [63:0] e1;
    logic [63:0] prod;
    e1   = 64'(taylor_exp_neg(64'(ONE_Q31)));
    t[0] = ONE_Q31;
    for (int k = 1; k < INT_TAB_SIZE; k++) begin
      prod = 64'(t[k-1]) * e1;
      t[k] = prod[62:31];
    end
    return t;
  endfunction

  function automatic frac_tab_t build_frac_pow();
    frac_tab_t t;
    for (int k = 0; k < FRAC_TAB_SIZE; k++) begin
      t[k] = taylor_exp_neg(64'(k) << (31 - EXP_TABLE_BITS));
    end
    return t;
  endfunction

  localparam int_tab_t  INT_POW  = build_int_pow();
  localparam frac_tab_t FRAC_POW = build_frac_pow();

endpackage

@@ design/gde_exp.sv @@
// Pipelined exp(-e) for e in Q16.16 below 128, result in Q1.31.
// Integer-power table times fraction table times a cubic for the low bits.
// Depends on gde_pkg; the pipeline advances only while en is high.
module gde_exp (
  input  logic                     clk,
  input  logic                     en,
  input  logic [gde_pkg::E_W-1:0]  e,
  output logic [31:0]              m
);

  localparam int RW = gde_pkg::R_W;

  logic [gde_pkg::INT_IDX_W-1:0]      n;
  logic [gde_pkg::EXP_TABLE_BITS-1:0] hi;
  logic [RW-1:0]                      r_in;

  logic [31:0]   ip_r, fp_r;
  logic [RW-1:0] r1_r;
  logic [31:0]   m1_r, m1b_r, m1c_r, m1d_r;
  logic [RW-1:0] r2_r, r2b_r, r2c_r;
  logic [RW-1:0] rb_r, rc_r, rd_r;
  logic [RW-1:0] r3_r, d6_r;
  logic [31:0]   p_r, m_r;

  logic [63:0]           ipfp, mp;
  logic [2*RW-1:0]       rr, r2r;
  logic [RW+27:0]        r3m;
  logic [32:0]           p_w;

  // split e into integer, table fraction and residual
  assign n    = e[16 +: gde_pkg::INT_IDX_W];
  assign hi   = e[gde_pkg::LO_W +: gde_pkg::EXP_TABLE_BITS];
  assign r_in = {e[gde_pkg::LO_W-1:0], 15'b0};

  assign ipfp = 64'(ip_r) * 64'(fp_r);
  assign rr   = (2*RW)'(r1_r) * (2*RW)'(r1_r);
  assign r2r  = (2*RW)'(r2_r) * (2*RW)'(rb_r);
  assign r3m  = (RW+28)'(r3_r) * (RW+28)'(gde_pkg::DIV6_RECIP);
  assign p_w  = 33'(gde_pkg::ONE_Q31) - 33'(rd_r) + 33'(r2c_r >> 1) - 33'(d6_r);
  assign mp   = 64'(m1d_r) * 64'(p_r);

  // advance all stages together
  always_ff @(posedge clk) begin
    if (en) begin
      ip_r  <= gde_pkg::INT_POW[n];
      fp_r  <= gde_pkg::FRAC_POW[hi];
      r1_r  <= r_in;
      // table product and r^2
      m1_r  <= ipfp[62:31];
      r2_r  <= RW'(rr >> 31);
      rb_r  <= r1_r;
      // r^3
      r3_r  <= RW'(r2r >> 31);
      m1b_r <= m1_r;
      r2b_r <= r2_r;
      rc_r  <= rb_r;
      // r^3 / 6
      d6_r  <= RW'(r3m >> gde_pkg::DIV6_SHIFT);
      m1c_r <= m1b_r;
      r2c_r <= r2b_r;
      rd_r  <= rc_r;
      // cubic
      p_r   <= p_w[31:0];
      m1d_r <= m1c_r;
      // final product
      m_r   <= mp[62:31];
    end
  end

  assign m = m_r;

endmodule

@@ design/gaussian_density_eval.sv @@
// Top level of the Gaussian density evaluator: config, offset, two long dividers, output.
// Depends on gde_pkg and gde_exp.
//
//  channel | dir | handshake           | payload
//  in_     | in  | in_tvalid/in_tready | in_tdata = abscissa (Q16.16 signed)
//  out_    | out | out_tvalid/tready   | out_tdata = density, out_tuser = saturated
//  cfg_    | in  | cfg_we              | cfg_addr = register, cfg_wdata = value
//
// One item per cycle while the skid register is empty; the pipeline is built mostly from
// the two restoring dividers that retire one quotient bit per stage
// (20 bits for z, 31 bits for the final scale) plus the six-stage exp unit.
// Reset (rst_n low, synchronous) empties the pipeline and loads mean 0, deviation 1.0.
// A result waiting at the output parks in a skid register; the whole pipeline
// stalls only while that skid register is full.
module gaussian_density_eval (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] abscissa
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] density
  output logic        out_tuser,  // [0] saturated
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [31:0] cfg_wdata
);

  localparam int N1 = gde_pkg::DIV1_STEPS;
  localparam int N2 = gde_pkg::DIV2_STEPS;
  localparam int XL = gde_pkg::EXP_LAT;

  logic [31:0] mean_r, dev_r;
  logic        en;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_r <= '0;
      dev_r  <= 32'd65536;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        gde_pkg::REG_MEAN: mean_r <= cfg_wdata;
        gde_pkg::REG_DEV:  dev_r  <= cfg_wdata;
        default:           mean_r <= mean_r;
      endcase
    end
  end

  // stage 1: offset, magnitude, deviation select
  logic signed [32:0] diff;
  logic [32:0]        ad;
  logic [30:0]        v_sel;
  gde_pkg::kind_t     kind_sel;

  logic               s1_val_r;
  logic [32:0]        s1_ad_r;
  logic [30:0]        s1_v_r;
  gde_pkg::kind_t     s1_kind_r;

  always_comb begin
    diff = {in_tdata[31], in_tdata} - {mean_r[31], mean_r};
    ad   = diff[32] ? 33'(-diff) : 33'(diff);
    if (dev_r == '0) begin
      v_sel    = 31'd1;
      kind_sel = gde_pkg::KIND_ZERO;
    end else if (dev_r[31]) begin
      v_sel    = 31'd65536;
      kind_sel = gde_pkg::KIND_NORM;
    end else begin
      v_sel    = dev_r[30:0];
      kind_sel = gde_pkg::KIND_NORM;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_val_r <= 1'b0;
    end else if (en) begin
      s1_val_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ad_r   <= ad;
      s1_v_r    <= v_sel;
      s1_kind_r <= kind_sel;
    end
  end

  // stage 2: far-tail check and divider load
  logic               d1_val_r  [N1+1];
  logic [30:0]        d1_rem_r  [N1+1];
  logic [N1-1:0]      d1_nb_r   [N1+1];
  logic [N1-1:0]      d1_q_r    [N1+1];
  logic [30:0]        d1_v_r    [N1+1];
  gde_pkg::kind_t     d1_kind_r [N1+1];
  logic               tail;

  assign tail = {2'b00, s1_ad_r} >= {s1_v_r, 4'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_val_r[0] <= 1'b0;
    end else if (en) begin
      d1_val_r[0] <= s1_val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_v_r[0] <= s1_v_r;
      d1_q_r[0] <= '0;
      if (tail) begin
        d1_rem_r[0] <= '0;
        d1_nb_r[0]  <= '0;
      end else begin
        d1_rem_r[0] <= 31'(s1_ad_r[32:4]);
        d1_nb_r[0]  <= {s1_ad_r[3:0], 16'b0};
      end
      if (s1_kind_r == gde_pkg::KIND_ZERO) begin
        d1_kind_r[0] <= gde_pkg::KIND_ZERO;
      end else if (tail) begin
        d1_kind_r[0] <= gde_pkg::KIND_TAIL;
      end else begin
        d1_kind_r[0] <= gde_pkg::KIND_NORM;
      end
    end
  end

  // z = (|x-mean| << 16) / dev, one quotient bit per stage
  for (genvar k = 0; k < N1; k++) begin : g_div1
    logic [31:0] trial;
    logic        ge;

    assign trial = {d1_rem_r[k], d1_nb_r[k][N1-1]};
    assign ge    = trial >= {1'b0, d1_v_r[k]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        d1_val_r[k+1] <= 1'b0;
      end else if (en) begin
        d1_val_r[k+1] <= d1_val_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d1_rem_r[k+1]  <= ge ? 31'(trial - {1'b0, d1_v_r[k]}) : trial[30:0];
        d1_nb_r[k+1]   <= d1_nb_r[k] << 1;
        d1_q_r[k+1]    <= {d1_q_r[k][N1-2:0], ge};
        d1_v_r[k+1]    <= d1_v_r[k];
        d1_kind_r[k+1] <= d1_kind_r[k];
      end
    end
  end

  // e = z*z/2, then the exp unit with a side line for the item's context
  logic [2*gde_pkg::Z_W-1:0] zz;
  logic [gde_pkg::E_W-1:0]   e_r;
  logic                      xs_val_r  [XL+1];
  logic [30:0]               xs_v_r    [XL+1];
  gde_pkg::kind_t            xs_kind_r [XL+1];
  logic [31:0]               m_exp;

  assign zz = (2*gde_pkg::Z_W)'(d1_q_r[N1]) * (2*gde_pkg::Z_W)'(d1_q_r[N1]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xs_val_r[0] <= 1'b0;
    end else if (en) begin
      xs_val_r[0] <= d1_val_r[N1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_r          <= zz[2*gde_pkg::Z_W-1:17];
      xs_v_r[0]    <= d1_v_r[N1];
      xs_kind_r[0] <= d1_kind_r[N1];
    end
  end

  for (genvar k = 0; k < XL; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        xs_val_r[k+1] <= 1'b0;
      end else if (en) begin
        xs_val_r[k+1] <= xs_val_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        xs_v_r[k+1]    <= xs_v_r[k];
        xs_kind_r[k+1] <= xs_kind_r[k];
      end
    end
  end

  gde_exp u_exp (
    .clk (clk),
    .en  (en),
    .e   (e_r),
    .m   (m_exp)
  );

  // scale by 1/sqrt(2*pi), keep the Q.63 product shifted down to Q.32
  logic [62:0]    pm;
  logic           d2_val_r  [N2+1];
  logic [30:0]    d2_rem_r  [N2+1];
  logic [N2-1:0]  d2_nb_r   [N2+1];
  logic [N2-1:0]  d2_q_r    [N2+1];
  logic [30:0]    d2_v_r    [N2+1];
  gde_pkg::kind_t d2_kind_r [N2+1];

  assign pm = 63'(m_exp) * 63'(gde_pkg::INV_SQRT_2PI_Q32);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d2_val_r[0] <= 1'b0;
    end else if (en) begin
      d2_val_r[0] <= xs_val_r[XL];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d2_rem_r[0]  <= '0;
      d2_nb_r[0]   <= pm[61:31];
      d2_q_r[0]    <= '0;
      d2_v_r[0]    <= xs_v_r[XL];
      d2_kind_r[0] <= xs_kind_r[XL];
    end
  end

  // density = scaled exp / dev, one quotient bit per stage
  for (genvar k = 0; k < N2; k++) begin : g_div2
    logic [31:0] trial;
    logic        ge;

    assign trial = {d2_rem_r[k], d2_nb_r[k][N2-1]};
    assign ge    = trial >= {1'b0, d2_v_r[k]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        d2_val_r[k+1] <= 1'b0;
      end else if (en) begin
        d2_val_r[k+1] <= d2_val_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d2_rem_r[k+1]  <= ge ? 31'(trial - {1'b0, d2_v_r[k]}) : trial[30:0];
        d2_nb_r[k+1]   <= d2_nb_r[k] << 1;
        d2_q_r[k+1]    <= {d2_q_r[k][N2-2:0], ge};
        d2_v_r[k+1]    <= d2_v_r[k];
        d2_kind_r[k+1] <= d2_kind_r[k];
      end
    end
  end

  // final stage: apply zero-deviation and far-tail overrides
  logic        fin_val_r;
  logic [31:0] fin_density_r;
  logic        fin_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_val_r <= 1'b0;
    end else if (en) begin
      fin_val_r <= d2_val_r[N2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      unique case (d2_kind_r[N2])
        gde_pkg::KIND_ZERO: begin
          fin_density_r <= '1;
          fin_sat_r     <= 1'b1;
        end
        gde_pkg::KIND_TAIL: begin
          fin_density_r <= '0;
          fin_sat_r     <= 1'b0;
        end
        default: begin
          fin_density_r <= {1'b0, d2_q_r[N2]};
          fin_sat_r     <= 1'b0;
        end
      endcase
    end
  end

  // output register with skid slot
  logic        out_valid_r, skid_valid_r;
  logic [31:0] out_density_r, skid_density_r;
  logic        out_sat_r, skid_sat_r;
  logic        take;

  assign en   = !skid_valid_r;
  assign take = out_valid_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      priority if (skid_valid_r) begin
        if (take) begin
          skid_valid_r <= 1'b0;
        end
      end else if (fin_val_r) begin
        if (!out_valid_r || take) begin
          out_valid_r <= 1'b1;
        end else begin
          skid_valid_r <= 1'b1;
        end
      end else if (take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    priority if (skid_valid_r) begin
      if (take) begin
        out_density_r <= skid_density_r;
        out_sat_r     <= skid_sat_r;
      end
    end else if (fin_val_r) begin
      if (!out_valid_r || take) begin
        out_density_r <= fin_density_r;
        out_sat_r     <= fin_sat_r;
      end else begin
        skid_density_r <= fin_density_r;
        skid_sat_r     <= fin_sat_r;
      end
    end else begin
      out_density_r <= out_density_r;
    end
  end

  assign in_tready  = en;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_density_r;
  assign out_tuser  = out_sat_r;

  // checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid slot full while output register empty");

  a_sat_is_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_sat_r |-> out_density_r == 32'hFFFF_FFFF)
    else $error("saturated result without maximum density");

  a_z_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    d1_val_r[N1] |-> d1_rem_r[N1] < d1_v_r[N1])
    else $error("z divider remainder not below divisor");

endmodule

@@ bench/tb_gaussian_density_eval.sv @@
// Testbench for gaussian_density_eval: drives abscissa transactions and checks
// every density result against a fixed-point predictor of the normal PDF.
// Depends on gde_pkg (register indexes) and the gaussian_density_eval RTL.
`timescale 1ns / 100ps

module tb_gaussian_density_eval;

  localparam int LATENCY = 63;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tuser;
  logic        cfg_we = 1'b0;
  logic        cfg_addr = gde_pkg::REG_MEAN;
  logic [31:0] cfg_wdata = '0;

  typedef struct packed {
    logic [31:0] density;
    logic        saturated;
  } density_t;

  density_t    pending_density[$];
  logic [31:0] mean_q = 32'd0;
  logic [31:0] dev_q = 32'd65536;
  logic [63:0] int_pow[128];
  logic [63:0] frac_pow[256];
  int          errors = 0;
  int          cycles = 0;
  bit          hold_off = 1'b0;

  gaussian_density_eval DUT (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_gaussian_density_eval failed");
      $finish;
    end
  end

  // Integer Taylor series of exp(-x), x and result in Q1.31
  function automatic logic [63:0] exp_taylor(input logic [63:0] x);
    longint      sum;
    logic [63:0] term;
    sum = 64'h8000_0000;
    term = 64'h8000_0000;
    for (int i = 1; i <= 20; i++) begin
      term = ((term * x) >> 31) / i;
      if (i % 2 == 1) sum -= longint'(term);
      else sum += longint'(term);
    end
    if (sum < 0) sum = 0;
    return 64'(sum);
  endfunction

  // Expected density for one abscissa under the current mean and deviation
  function automatic density_t predict_density(input logic [31:0] x);
    density_t    res;
    longint      d, dv;
    logic [63:0] ad, z, e, r, r2, r3, p, m, q;
    dv = longint'($signed(dev_q));
    if (dv < 0) dv = 65536;
    if (dv == 0) return '{32'hFFFF_FFFF, 1'b1};
    d = longint'($signed(x)) - longint'($signed(mean_q));
    ad = (d < 0) ? 64'(-d) : 64'(d);
    z = (ad << 16) / 64'(dv);
    if (z >= 64'(1) << 20) return '{32'd0, 1'b0};
    e = (z * z) >> 17;
    r = (e & 64'hFF) << 15;
    r2 = (r * r) >> 31;
    r3 = (r2 * r) >> 31;
    p = 64'h8000_0000 - r + (r2 >> 1) - r3 / 6;
    m = (int_pow[(e >> 16) & 127] * frac_pow[(e >> 8) & 255]) >> 31;
    m = (m * p) >> 31;
    q = ((m * 64'd1713444047) / 64'(dv)) >> 31;
    if (q > 64'hFFFF_FFFF) res = '{32'hFFFF_FFFF, 1'b1};
    else res = '{q[31:0], 1'b0};
    return res;
  endfunction

  // Receiver: stall on its own pattern, or hold off entirely when asked
  always @(posedge clk) begin
    if (hold_off) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(0, 99) < (cycles % 2000 < 600 ? 100 : 70));
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    density_t exp_d;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_density.size() == 0) begin
        $error("unexpected result density=%h saturated=%b", out_tdata, out_tuser);
        errors++;
      end else begin
        exp_d = pending_density.pop_front();
        if (out_tdata !== exp_d.density) begin
          $error("density expected %h actual %h", exp_d.density, out_tdata);
          errors++;
        end
        if (out_tuser !== exp_d.saturated) begin
          $error("saturated expected %b actual %b", exp_d.saturated, out_tuser);
          errors++;
        end
      end
    end
  end

  // Send one abscissa; predict at acceptance
  task automatic send_abscissa(input logic [31:0] x);
    in_tvalid <= 1'b1;
    in_tdata <= x;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_density.push_back(predict_density(x));
  endtask

  task automatic lower_valid();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // Bursts of random length separated by random gaps
  task automatic send_burst(input logic [31:0] x);
    send_abscissa(x);
    if ($urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    lower_valid();
    while (pending_density.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  // One register write, then the write port goes idle
  task automatic write_reg(input logic addr, input logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (addr == gde_pkg::REG_MEAN) mean_q = value;
    else dev_q = value;
    @(posedge clk);
  endtask

  // Random abscissa near the mean in units of the deviation, or anywhere
  function automatic logic [31:0] random_abscissa();
    longint dv, off;
    dv = longint'($signed(dev_q));
    if (dv <= 0) dv = 65536;
    if ($urandom_range(0, 9) == 0) return $urandom;
    off = (longint'($urandom_range(0, 20 * 4096)) * dv) >>> 12;
    if ($urandom_range(0, 1)) off = -off;
    return 32'(longint'($signed(mean_q)) + off);
  endfunction

  task automatic test_extremes();
    logic [31:0] pts[$] = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                            32'h0001_0000, 32'hFFFF_0000, 32'h0000_0001,
                            32'h0010_0000, 32'h000F_FFFF, 32'h5555_5555,
                            32'hAAAA_AAAA, 32'h0000_8000};
    foreach (pts[i]) send_abscissa(pts[i]);
    wait_drained();
  endtask

  task automatic test_deviation_cases();
    write_reg(gde_pkg::REG_DEV, 32'd0);
    send_abscissa(32'h1234_5678);
    send_abscissa(32'h0);
    wait_drained();
    write_reg(gde_pkg::REG_DEV, 32'hFFFF_0000);
    send_abscissa(32'h0);
    send_abscissa(32'h0002_0000);
    wait_drained();
    write_reg(gde_pkg::REG_DEV, 32'd1);
    write_reg(gde_pkg::REG_MEAN, 32'h0000_0100);
    send_abscissa(32'h0000_0100);
    send_abscissa(32'h0000_0101);
    wait_drained();
    write_reg(gde_pkg::REG_DEV, 32'h7FFF_FFFF);
    write_reg(gde_pkg::REG_MEAN, 32'h8000_0000);
    send_abscissa(32'h7FFF_FFFF);
    send_abscissa(32'h8000_0000);
    wait_drained();
  endtask

  task automatic test_random_settings();
    logic [31:0] devs[$] = '{32'h0001_0000, 32'h0000_0100, 32'h0040_0000,
                             32'h8000_0000, 32'h0000_0010, 32'h7FFF_FFFF};
    foreach (devs[s]) begin
      write_reg(gde_pkg::REG_MEAN,
                (s % 2) ? $urandom : 32'($signed($urandom_range(0, 1 << 20))));
      write_reg(gde_pkg::REG_DEV, (s == 0) ? devs[s] :
                (($urandom_range(0, 1)) ? devs[s] : $urandom_range(1, 32'h0100_0000)));
      repeat (110) send_burst(random_abscissa());
      wait_drained();
    end
  endtask

  // Hold the receiver off while the sender keeps offering items
  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      repeat (100) send_abscissa(random_abscissa());
      repeat (300) @(posedge clk);
    join_any
    hold_off = 1'b0;
    wait fork;
    wait_drained();
  endtask

  initial begin
    foreach (int_pow[k]) int_pow[k] = (k == 0) ? 64'h8000_0000 :
        (int_pow[k-1] * exp_taylor(64'h8000_0000)) >> 31;
    foreach (frac_pow[k]) frac_pow[k] = exp_taylor(64'(k) << 23);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_deviation_cases();
    test_random_settings();
    test_backpressure();
    if (errors == 0) begin
      $display("tb_gaussian_density_eval passed");
    end else begin
      $display("tb_gaussian_density_eval failed");
    end
    $finish;
  end
endmodule

@@ gaussian_density_eval.f @@
design/gde_pkg.sv
design/gde_exp.sv
design/gaussian_density_eval.sv
bench/tb_gaussian_density_eval.sv
